>>> sv/nqts_pkg.sv
// Shared widths, codes and rounding helpers for the noisy quadrature tone source.
package nqts_pkg;

   // Field and register widths.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;
   localparam int STEP_W     = 18;
   localparam int GAIN_W     = 16;
   localparam int PAIRS_W    = 13;
   localparam int INDEX_W    = 12;
   localparam int SAMPLE_W   = 16;
   localparam int PHASOR_W   = 32;
   localparam int NOISE_SHIFT = 18;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = SAMPLE_W + NOISE_SHIFT + 1;
   localparam int MUL_B_W = STEP_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Rounding shifts for the phasor update and the scaled output.
   localparam int ROT_SHIFT = 16;
   localparam int OUT_SHIFT = 34;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_COS_STEP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_STEP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_PAIRS = 2'd3;

   // Request opcodes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Reset values.
   localparam logic signed [PHASOR_W-1:0] PHASOR_ONE     = 32'sh4000_0000;
   localparam logic signed [STEP_W-1:0]   COS_STEP_RESET = 18'sd65536;
   localparam logic [PAIRS_W-1:0]         PAIRS_RESET    = 13'd4096;

   localparam logic signed [PROD_W-1:0] HALF_ROT = PROD_W'(64'd1 << (ROT_SHIFT - 1));
   localparam logic signed [PROD_W-1:0] HALF_OUT = PROD_W'(64'd1 << (OUT_SHIFT - 1));

   // Round to nearest (ties up) by 2^16 and saturate to the phasor width.
   function automatic logic signed [PHASOR_W-1:0] round_phasor(
      input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W-1:0]           y;
      logic [PROD_W-ROT_SHIFT-1:0]        s;
      logic [PROD_W-ROT_SHIFT-PHASOR_W:0] top;
      y   = x + HALF_ROT;
      s   = y[PROD_W-1:ROT_SHIFT];
      top = s[PROD_W-ROT_SHIFT-1:PHASOR_W-1];
      if ((&top) || !(|top)) begin
         round_phasor = s[PHASOR_W-1:0];
      end else if (s[PROD_W-ROT_SHIFT-1]) begin
         round_phasor = {1'b1, {(PHASOR_W-1){1'b0}}};
      end else begin
         round_phasor = {1'b0, {(PHASOR_W-1){1'b1}}};
      end
   endfunction

   // Round to nearest (ties up) by 2^34 and saturate to the sample width.
   function automatic logic signed [SAMPLE_W-1:0] round_sample(
      input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W-1:0]           y;
      logic [PROD_W-OUT_SHIFT-1:0]        s;
      logic [PROD_W-OUT_SHIFT-SAMPLE_W:0] top;
      y   = x + HALF_OUT;
      s   = y[PROD_W-1:OUT_SHIFT];
      top = s[PROD_W-OUT_SHIFT-1:SAMPLE_W-1];
      if ((&top) || !(|top)) begin
         round_sample = s[SAMPLE_W-1:0];
      end else if (s[PROD_W-OUT_SHIFT-1]) begin
         round_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         round_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   endfunction

endpackage

>>> sv/nqts_mul.sv
// Shared signed multiplier with a registered product.
module nqts_mul
   import nqts_pkg::*;
(
   input  logic                       clock,
   input  logic                       issue,
   input  logic signed [MUL_A_W-1:0]  opa,
   input  logic signed [MUL_B_W-1:0]  opb,
   output logic signed [PROD_W-1:0]   prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // Full-width signed product; the operands are sign-extended first.
   assign prod_in = PROD_W'(opa) * PROD_W'(opb);

   // The product holds until the next issue.
   always_ff @(posedge clock) begin
      if (issue) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

>>> sv/noisy_quadrature_tone_source.sv
// Noisy quadrature tone source: sequencer, phasor state, noise table and result register.
// A load transfer is taken while the block is idle and writes the noise table directly.
// A tick runs four rotation products, a commit step, two gain products and an output step, which
// share one 35x18 multiplier; ready stays low until the result has left the output step.
// A new tick is taken only after the last one is through; loads go one per cycle while idle.
// Reset restores the configuration defaults, the phasor to 1+0j and the pointer to zero;
// noise table contents are not cleared.
module noisy_quadrature_tone_source
   import nqts_pkg::*;
#(
   parameter int NOISE_DEPTH = 4096
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [INDEX_W-1:0]          req_noise_index,
   input  logic signed [SAMPLE_W-1:0]  req_noise_in_i,
   input  logic signed [SAMPLE_W-1:0]  req_noise_in_q,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SAMPLE_W-1:0]  rsp_sample_i,
   output logic signed [SAMPLE_W-1:0]  rsp_sample_q,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data
);

   localparam int PW = $clog2(NOISE_DEPTH);
   localparam int CW = (PW + 1 > PAIRS_W) ? PW + 1 : PAIRS_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(NOISE_DEPTH);

   // Sequencer step codes.
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RC     = 4'd1;
   localparam logic [3:0] ST_IS     = 4'd2;
   localparam logic [3:0] ST_RS     = 4'd3;
   localparam logic [3:0] ST_IC     = 4'd4;
   localparam logic [3:0] ST_COMMIT = 4'd5;
   localparam logic [3:0] ST_GI     = 4'd6;
   localparam logic [3:0] ST_GQ     = 4'd7;
   localparam logic [3:0] ST_OUT    = 4'd8;

   logic [3:0]                  step_ff, step_in;
   logic signed [STEP_W-1:0]    cos_ff, sin_ff;
   logic [GAIN_W-1:0]           gain_ff;
   logic [PAIRS_W-1:0]          pairs_ff;
   logic signed [PHASOR_W-1:0]  re_ff, im_ff, re_new_ff;
   logic [PW-1:0]               ptr_ff;
   logic signed [PROD_W-1:0]    acc_ff;
   logic signed [MUL_A_W-1:0]   sum_ff;
   logic signed [SAMPLE_W-1:0]  res_i_ff;
   logic [2*SAMPLE_W-1:0]       noise_rd_ff;
   logic                        rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]  rsp_i_ff, rsp_q_ff;
   logic [2*SAMPLE_W-1:0]       noise_mem [NOISE_DEPTH];

   logic                        req_xfer, tick_xfer, load_xfer, out_free;
   logic                        mul_issue;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]    prod;
   logic [CW-1:0]               ld_addr_ext, pairs_eff, ptr_plus;
   logic [PW-1:0]               ptr_next;
   logic signed [MUL_A_W-1:0]   noise_i_ext, noise_q_ext;

   assign req_ready = (step_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign tick_xfer = req_xfer && (req_opcode == OP_TICK);
   assign load_xfer = req_xfer && (req_opcode == OP_LOAD);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Sequencer: walks the rotation and gain products for one tick.
   always_comb begin
      step_in = step_ff;
      unique case (step_ff)
         ST_IDLE:   if (tick_xfer) step_in = ST_RC;
         ST_RC:     step_in = ST_IS;
         ST_IS:     step_in = ST_RS;
         ST_RS:     step_in = ST_IC;
         ST_IC:     step_in = ST_COMMIT;
         ST_COMMIT: step_in = ST_GI;
         ST_GI:     step_in = ST_GQ;
         ST_GQ:     step_in = ST_OUT;
         ST_OUT:    if (out_free) step_in = ST_IDLE;
         default:   step_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_issue = 1'b0;
      mul_a     = MUL_A_W'(re_ff);
      mul_b     = cos_ff;
      case (step_ff)
         ST_RC: begin
            mul_issue = 1'b1;
         end
         ST_IS: begin
            mul_issue = 1'b1;
            mul_a     = MUL_A_W'(im_ff);
            mul_b     = sin_ff;
         end
         ST_RS: begin
            mul_issue = 1'b1;
            mul_b     = sin_ff;
         end
         ST_IC: begin
            mul_issue = 1'b1;
            mul_a     = MUL_A_W'(im_ff);
         end
         ST_GI, ST_GQ: begin
            mul_issue = 1'b1;
            mul_a     = sum_ff;
            mul_b     = $signed({2'b00, gain_ff});
         end
         default: begin
            mul_issue = 1'b0;
         end
      endcase
   end

   nqts_mul u_mul (
      .clock (clock),
      .issue (mul_issue),
      .opa   (mul_a),
      .opb   (mul_b),
      .prod  (prod)
   );

   // Noise pair scaled to the Q2.30 grid of the phasor.
   assign noise_i_ext = $signed({noise_rd_ff[2*SAMPLE_W-1], noise_rd_ff[2*SAMPLE_W-1:SAMPLE_W],
                                 {NOISE_SHIFT{1'b0}}});
   assign noise_q_ext = $signed({noise_rd_ff[SAMPLE_W-1], noise_rd_ff[SAMPLE_W-1:0],
                                 {NOISE_SHIFT{1'b0}}});

   // Datapath registers that accumulate, round and sum across the steps.
   always_ff @(posedge clock) begin
      case (step_ff)
         ST_IS, ST_IC: acc_ff <= prod;
         ST_RS:        re_new_ff <= round_phasor(acc_ff - prod);
         ST_COMMIT:    sum_ff <= noise_i_ext + MUL_A_W'(re_new_ff);
         ST_GI:        sum_ff <= noise_q_ext + MUL_A_W'(im_ff);
         ST_GQ:        res_i_ff <= round_sample(prod);
         default: begin
         end
      endcase
   end

   // Effective pair count and the wrapped pointer increment.
   always_comb begin
      pairs_eff = CW'(pairs_ff);
      if (pairs_eff == '0) begin
         pairs_eff = CW'(1);
      end else if (pairs_eff > DEPTH_C) begin
         pairs_eff = DEPTH_C;
      end
      ptr_plus = CW'(ptr_ff) + CW'(1);
      ptr_next = (ptr_plus >= pairs_eff) ? '0 : ptr_plus[PW-1:0];
   end

   // Phasor and pointer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         re_ff  <= PHASOR_ONE;
         im_ff  <= '0;
         ptr_ff <= '0;
      end else if (step_ff == ST_COMMIT) begin
         re_ff  <= re_new_ff;
         im_ff  <= round_phasor(acc_ff + prod);
         ptr_ff <= ptr_next;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff   <= COS_STEP_RESET;
         sin_ff   <= '0;
         gain_ff  <= '0;
         pairs_ff <= PAIRS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COS_STEP:    cos_ff   <= $signed(csr_data[STEP_W-1:0]);
            CSR_SIN_STEP:    sin_ff   <= $signed(csr_data[STEP_W-1:0]);
            CSR_GAIN:        gain_ff  <= csr_data[GAIN_W-1:0];
            CSR_NOISE_PAIRS: pairs_ff <= csr_data[PAIRS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Noise table: one write port for loads, one registered read for ticks.
   assign ld_addr_ext = CW'(req_noise_index);

   always_ff @(posedge clock) begin
      if (load_xfer && (ld_addr_ext < DEPTH_C)) begin
         noise_mem[ld_addr_ext[PW-1:0]] <= {req_noise_in_i, req_noise_in_q};
      end
   end

   always_ff @(posedge clock) begin
      if (tick_xfer) begin
         noise_rd_ff <= noise_mem[ptr_ff];
      end
   end

   // Result register; a finished tick waits here until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_ff == ST_OUT && out_free) begin
         rsp_i_ff <= res_i_ff;
         rsp_q_ff <= round_sample(prod);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sample_i = rsp_i_ff;
   assign rsp_sample_q = rsp_q_ff;

   // A tick transfer holds off further requests while it is in progress.
   a_tick_blocks: assert property (@(posedge clock) disable iff (reset)
      tick_xfer |=> !req_ready)
      else $error("request accepted during a tick");

   // A load transfer leaves the block ready for the next request.
   a_load_fast: assert property (@(posedge clock) disable iff (reset)
      load_xfer |=> req_ready)
      else $error("load transfer stalled the block");

   // The phasor changes only at the commit step or on reset.
   a_phasor_commit: assert property (@(posedge clock) disable iff (reset)
      !$stable(re_ff) |-> ($past(step_ff) == ST_COMMIT || $past(reset)))
      else $error("phasor changed outside the commit step");

   // A new result appears only from the final output step.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff) == ST_OUT)
      else $error("result raised outside the output step");

endmodule
